### rtl/atmg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atmg_pkg: shared types, widths and gamma threshold table
// Widths cover any scale from 2^8 to 2^16; the threshold table holds
// floor(2^QUO_W * (b/255)^(20/9)) for every output code b below the top one.
// ----------------------------------------------------------------------------
package atmg_pkg;

	localparam int unsigned LANES  = 3;
	localparam int unsigned IN_W   = 16;
	localparam int unsigned OUT_W  = 8;
	// 251*x + 3*s and 243*x + 59*s with s up to 2^16
	localparam int unsigned ASUM_W = IN_W + 8;
	localparam int unsigned DSUM_W = IN_W + 9;
	localparam int unsigned NUM_W  = IN_W + ASUM_W;
	localparam int unsigned DEN_W  = IN_W + DSUM_W;
	// quotient bits of num/den kept for the threshold search
	localparam int unsigned QUO_W  = 40;
	// wide scratch for exact table construction: X^9 * 255^20 < 2^520
	localparam int unsigned BIG_W  = 9 * QUO_W + 168;
	localparam int unsigned CODES  = 1 << OUT_W;

	typedef struct packed {
		logic valid;
		logic sat;
	} lane_ctl_t;

	typedef logic [CODES-1:0][QUO_W-1:0] thr_tab_t;

	// Exact thresholds: largest x with x^9 * 255^20 <= b^20 * 2^(9*QUO_W).
	// Top code never matches; code zero is never probed.
	function automatic thr_tab_t build_thr();
		thr_tab_t          tab;
		logic [BIG_W-1:0]  k255;
		logic [BIG_W-1:0]  rhs;
		logic [BIG_W-1:0]  lhs;
		logic [QUO_W-1:0]  x;
		logic [QUO_W-1:0]  trial;
		k255 = BIG_W'(1);
		for (int i = 0; i < 20; i++) begin
			k255 = k255 * BIG_W'(255);
		end
		tab = '0;
		for (int b = 1; b < CODES - 1; b++) begin
			rhs = BIG_W'(1);
			for (int i = 0; i < 20; i++) begin
				rhs = rhs * BIG_W'(b);
			end
			rhs = rhs << (9 * QUO_W);
			x = '0;
			for (int k = QUO_W - 1; k >= 0; k--) begin
				trial = x | (QUO_W'(1) << k);
				lhs = k255;
				for (int i = 0; i < 9; i++) begin
					lhs = lhs * BIG_W'(trial);
				end
				if (lhs <= rhs) begin
					x = trial;
				end
			end
			tab[b] = x;
		end
		tab[CODES-1] = '1;
		return tab;
	endfunction

	localparam thr_tab_t GAMMA_THR = build_thr();

endpackage
`default_nettype wire

### rtl/atmg_ratio.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atmg_ratio: filmic curve numerator/denominator and pipelined divider
// Forms num = x(251x + 3s), den = x(243x + 59s) + 14s^2, flags num >= den
// as saturated, then produces floor(num * 2^QUO_W / den) one bit per stage.
// ----------------------------------------------------------------------------
module atmg_ratio #(
	parameter int unsigned FRACTION_BITS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [atmg_pkg::IN_W-1:0]    lin,
	output atmg_pkg::lane_ctl_t               ctl,
	output logic      [atmg_pkg::QUO_W-1:0]   quo
);
	import atmg_pkg::*;

	localparam logic [ASUM_W-1:0] A_OFS   = ASUM_W'(3) << FRACTION_BITS;
	localparam logic [DSUM_W-1:0] D_OFS   = DSUM_W'(59) << FRACTION_BITS;
	localparam logic [DEN_W-1:0]  DEN_OFS = DEN_W'(14) << (2 * FRACTION_BITS);

	logic [IN_W-1:0]   lin_s1;
	logic [ASUM_W-1:0] asum_s1;
	logic [DSUM_W-1:0] dsum_s1;
	logic              vld_s1;
	logic [NUM_W-1:0]  num_s2;
	logic [DEN_W-1:0]  den_s2;
	logic              vld_s2;
	logic              sat;

	lane_ctl_t         ctl_s [QUO_W+1];
	logic [DEN_W-1:0]  rem_s [QUO_W];
	logic [DEN_W-1:0]  dvs_s [QUO_W];
	logic [QUO_W-1:0]  quo_s [QUO_W+1];

	// valid bits of the product stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// inner linear terms, then the two products
	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1  <= lin;
			asum_s1 <= ASUM_W'(251) * ASUM_W'(lin) + A_OFS;
			dsum_s1 <= DSUM_W'(243) * DSUM_W'(lin) + D_OFS;
			num_s2  <= NUM_W'(lin_s1) * NUM_W'(asum_s1);
			den_s2  <= DEN_W'(lin_s1) * DEN_W'(dsum_s1) + DEN_OFS;
		end
	end

	// curve at or above one clamps to full scale
	assign sat = DEN_W'(num_s2) >= den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].valid <= vld_s2;
			ctl_s[0].sat   <= sat;
		end
	end

	// divider setup: remainder starts at num, below den unless clamped, or at zero if clamped
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sat ? '0 : DEN_W'(num_s2);
			dvs_s[0] <= den_s2;
			quo_s[0] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [DEN_W:0] shl;
		logic [DEN_W:0] diff;
		logic           ge;

		assign shl  = {rem_s[k], 1'b0};
		assign diff = shl - {1'b0, dvs_s[k]};
		assign ge   = ~diff[DEN_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
			end
		end

		if (k < QUO_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[DEN_W-1:0] : shl[DEN_W-1:0];
					dvs_s[k+1] <= dvs_s[k];
				end
			end
		end
	end

	assign ctl = ctl_s[QUO_W];
	assign quo = quo_s[QUO_W];

endmodule
`default_nettype wire

### rtl/atmg_gamma.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atmg_gamma: gamma encode by pipelined search of the threshold table
// One output bit per stage, MSB first: a code is kept when the quotient lies
// strictly above its threshold. Clamped pixels give full scale.
// ----------------------------------------------------------------------------
module atmg_gamma (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire atmg_pkg::lane_ctl_t          ctl_in,
	input  wire logic [atmg_pkg::QUO_W-1:0]   quo_in,
	output atmg_pkg::lane_ctl_t               ctl_out,
	output logic      [atmg_pkg::OUT_W-1:0]   display
);
	import atmg_pkg::*;

	lane_ctl_t        ctl_s  [OUT_W+1];
	logic [QUO_W-1:0] quo_s  [OUT_W];
	logic [OUT_W-1:0] code_s [OUT_W+1];

	assign ctl_s[0]  = ctl_in;
	assign quo_s[0]  = quo_in;
	assign code_s[0] = '0;

	for (genvar j = 0; j < OUT_W; j++) begin : g_srch
		localparam logic [OUT_W-1:0] PROBE = OUT_W'(1) << (OUT_W - 1 - j);
		logic [OUT_W-1:0] cand;
		logic             take;

		// try the next lower bit against its threshold
		assign cand = code_s[j] | PROBE;
		assign take = quo_s[j] > GAMMA_THR[cand];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				code_s[j+1] <= take ? cand : code_s[j];
			end
		end

		if (j < OUT_W - 1) begin : g_quo
			always_ff @(posedge clk) begin
				if (en) begin
					quo_s[j+1] <= quo_s[j];
				end
			end
		end
	end

	assign ctl_out = ctl_s[OUT_W];
	assign display = ctl_s[OUT_W].sat ? '1 : code_s[OUT_W];

endmodule
`default_nettype wire

### rtl/atmg_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atmg_merge: joins the lane results into one pixel and buffers the output
// Output register plus one skid entry; the lane pipelines advance while the
// skid entry is free.
// ----------------------------------------------------------------------------
module atmg_merge (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire atmg_pkg::lane_ctl_t [atmg_pkg::LANES-1:0]         lane_ctl,
	input  wire logic [atmg_pkg::LANES-1:0][atmg_pkg::OUT_W-1:0]   lane_px,
	output logic                                                   en,
	output logic                                                   m_tvalid,
	input  wire logic                                              m_tready,
	output logic      [atmg_pkg::LANES*atmg_pkg::OUT_W-1:0]        m_tdata
);
	import atmg_pkg::*;

	localparam int unsigned PX_W = LANES * OUT_W;

	logic            pipe_vld;
	logic            out_vld_q;
	logic            skid_vld_q;
	logic [PX_W-1:0] out_px_q;
	logic [PX_W-1:0] skid_px_q;
	logic            out_free;

	// all lanes carry the same pixel
	always_comb begin
		pipe_vld = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			pipe_vld = pipe_vld & lane_ctl[i].valid;
		end
	end

	assign en       = ~skid_vld_q;
	assign out_free = ~out_vld_q | m_tready;

	// occupancy of output and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q  <= skid_vld_q | pipe_vld;
			skid_vld_q <= 1'b0;
		end else if (pipe_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	// pixel data
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_px_q <= skid_vld_q ? skid_px_q : lane_px;
		end else if (pipe_vld && en) begin
			skid_px_q <= lane_px;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_px_q;

endmodule
`default_nettype wire

### rtl/aces_tone_map_gamma_top.sv
`default_nettype none
// Throughput: one pixel per clock while the skid entry is free, all three
// channels in parallel. Depth is set by the 40-stage restoring divider and
// 8-stage table search in each channel lane; a skid entry absorbs one pixel
// of output backpressure.
// Reset clears all valid bits at once; no clearing pass, ready right after.
// ----------------------------------------------------------------------------
// aces_tone_map_gamma_top: ACES filmic tone map with gamma encoding
// Three channel lanes of curve, divider and gamma search, merged into one
// display pixel.
// ----------------------------------------------------------------------------
module aces_tone_map_gamma_top #(
	parameter int unsigned FRACTION_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] red_linear, [31:16] green_linear, [47:32] blue_linear
	input  wire logic [47:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] red_display, [15:8] green_display, [23:16] blue_display
	output logic      [23:0] m_axis_tdata
);
	import atmg_pkg::*;

	logic                             en;
	lane_ctl_t [LANES-1:0]            ratio_ctl;
	logic      [LANES-1:0][QUO_W-1:0] ratio_quo;
	lane_ctl_t [LANES-1:0]            lane_ctl;
	logic      [LANES-1:0][OUT_W-1:0] lane_px;
	logic      [LANES-1:0]            lane_vld;

	// one lane per color channel
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		atmg_ratio #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_ratio (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_valid(s_axis_tvalid),
			.lin     (s_axis_tdata[i*IN_W +: IN_W]),
			.ctl     (ratio_ctl[i]),
			.quo     (ratio_quo[i])
		);

		atmg_gamma u_gamma (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ratio_ctl[i]),
			.quo_in (ratio_quo[i]),
			.ctl_out(lane_ctl[i]),
			.display(lane_px[i])
		);

		assign lane_vld[i] = lane_ctl[i].valid;
	end

	// merge lanes and drive the output stream
	atmg_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.lane_ctl(lane_ctl),
		.lane_px (lane_px),
		.en      (en),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata (m_axis_tdata)
	);

	assign s_axis_tready = en;

	// lanes run identical valid pipelines from one input valid and must never disagree
	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(&lane_vld) == (|lane_vld))
		else $error("channel lanes out of step");

	// input held off only while a pixel waits on the output
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// skid fills only from a held output
	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("skid filled without output backpressure");

	// skid drains as soon as the output is taken
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_axis_tready && m_axis_tready) |=> s_axis_tready)
		else $error("skid entry not drained");

endmodule
`default_nettype wire
